// ===== design/mtcqf_pkg.sv =====
package mtcqf_pkg;

  // MIDI status for a quarter-frame message
  localparam logic [7:0] MTC_STATUS = 8'hF1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE = 1'b1;

  // Quarter-frame piece that carries hours high bits and the rate type
  localparam logic [2:0] PIECE_HOUR_HI = 3'd7;

  // Frame rate as kept in state
  typedef enum logic [1:0] {
    RATE_24 = 2'd0,
    RATE_25 = 2'd1,
    RATE_30 = 2'd2
  } rate_e;

  // Time counters
  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] frame;
  } cnt_t;

  // Per-request decode outcome
  typedef struct packed {
    logic        emit;
    logic [26:0] time_ms;
    logic        time_valid;
  } dec_res_t;

  // Register value in frames per second to rate code; values other than 24 and 30 mean 25
  function automatic rate_e rate_of_fps(input logic [7:0] fps);
    rate_e r;
    r = RATE_25;
    if (fps == 8'd24) r = RATE_24;
    if (fps == 8'd30) r = RATE_30;
    return r;
  endfunction

  // SMPTE type from piece 7 (nibble bits 3:1) to rate code
  function automatic rate_e rate_of_kind(input logic [2:0] kind);
    rate_e r;
    case (kind)
      3'd0:        r = RATE_24;
      3'd2, 3'd3:  r = RATE_30;
      default:     r = RATE_25;
    endcase
    return r;
  endfunction

  // Exact floor(x/3) for x < 2^12 via reciprocal multiply
  function automatic logic [10:0] div3(input logic [11:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'd43691;
    return prod[27:17];
  endfunction

  // Exact floor(x/60) for x <= 256
  function automatic logic [2:0] div60(input logic [8:0] x);
    logic [13:0] prod;
    prod = 14'(x[8:2]) * 14'd137;
    return prod[13:11];
  endfunction

endpackage

// ===== design/mtcqf_if.sv =====
// Incoming MIDI message channel
interface mtcqf_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] data_byte;

  modport source (output valid, status_byte, data_byte, input ready);
  modport sink   (input valid, status_byte, data_byte, output ready);
endinterface

// Decoded time channel
interface mtcqf_time_if;
  logic        valid;
  logic        ready;
  logic [26:0] time_ms;
  logic        time_valid;

  modport source (output valid, time_ms, time_valid, input ready);
  modport sink   (input valid, time_ms, time_valid, output ready);
endinterface

// Configuration write channel
interface mtcqf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mtcqf_pkg::CFG_IDX_W-1:0]     index;
  logic [7:0]                          wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== design/mtcqf_decode.sv =====
// Combinational quarter-frame update: counter advance, time conversion,
// nibble store and rate load for one message.
module mtcqf_decode (
  input  mtcqf_pkg::cnt_t     cnt_i,
  input  mtcqf_pkg::rate_e    rate_i,
  input  logic [6:0]          data_byte_i,
  output mtcqf_pkg::cnt_t     cnt_o,
  output mtcqf_pkg::rate_e    rate_o,
  output mtcqf_pkg::dec_res_t res_o
);

  logic [2:0]      piece;
  logic [3:0]      nib;
  logic [4:0]      fps;
  logic [8:0]      f_inc, s_inc, m_inc;
  logic [3:0]      f_quo;
  logic [8:0]      f_mod, s_mod, m_mod;
  logic            f_wrap, s_wrap, m_wrap;
  mtcqf_pkg::cnt_t adv;
  mtcqf_pkg::cnt_t stored;
  logic [9:0]      frame_ms;
  logic [26:0]     sum_ms;
  logic            ok;
  logic [7:0]      slot;

  assign piece = data_byte_i[6:4];
  assign nib   = data_byte_i[3:0];

  // Frame modulo by the current rate
  always_comb begin
    f_inc = 9'(cnt_i.frame) + 9'd1;
    case (rate_i)
      mtcqf_pkg::RATE_24: begin
        fps   = 5'd24;
        f_quo = 4'(mtcqf_pkg::div3(12'(f_inc[8:3])));
      end
      mtcqf_pkg::RATE_30: begin
        fps   = 5'd30;
        f_quo = 4'((15'(f_inc[8:1]) * 15'd137) >> 11);
      end
      default: begin
        fps   = 5'd25;
        f_quo = 4'((14'(f_inc) * 14'd41) >> 10);
      end
    endcase
    f_mod  = f_inc - 9'(f_quo) * 9'(fps);
    f_wrap = f_inc >= 9'(fps);
  end

  // Carry chain into seconds, minutes and hours
  always_comb begin
    s_inc  = 9'(cnt_i.second) + 9'd1;
    m_inc  = 9'(cnt_i.minute) + 9'd1;
    s_mod  = s_inc - 9'(mtcqf_pkg::div60(s_inc)) * 9'd60;
    m_mod  = m_inc - 9'(mtcqf_pkg::div60(m_inc)) * 9'd60;
    s_wrap = f_wrap && (s_inc >= 9'd60);
    m_wrap = s_wrap && (m_inc >= 9'd60);

    adv.frame  = f_mod[7:0];
    adv.second = f_wrap ? s_mod[7:0] : cnt_i.second;
    adv.minute = s_wrap ? m_mod[7:0] : cnt_i.minute;
    adv.hour   = m_wrap ? cnt_i.hour + 8'd1 : cnt_i.hour;
  end

  // Milliseconds since midnight; frame part is floor(f*1000/fps)
  always_comb begin
    case (rate_i)
      mtcqf_pkg::RATE_24: frame_ms = 10'(mtcqf_pkg::div3(12'(adv.frame[4:0]) * 12'd125));
      mtcqf_pkg::RATE_30: frame_ms = 10'(mtcqf_pkg::div3(12'(adv.frame[4:0]) * 12'd100));
      default:            frame_ms = 10'(adv.frame[4:0]) * 10'd40;
    endcase
    ok = (adv.hour < 8'd24) && (adv.minute < 8'd60) && (adv.second < 8'd60);
    sum_ms = 27'(adv.hour[4:0]) * 27'd3600000
           + 27'(adv.minute[5:0]) * 27'd60000
           + 27'(adv.second[5:0]) * 27'd1000
           + 27'(frame_ms);
  end

  assign res_o.emit       = (piece[1:0] == 2'd0);
  assign res_o.time_valid = ok;
  assign res_o.time_ms    = ok ? sum_ms : 27'd0;

  // Nibble store into the addressed counter
  always_comb begin
    stored = res_o.emit ? adv : cnt_i;
    case (piece[2:1])
      2'd0:    slot = stored.frame;
      2'd1:    slot = stored.second;
      2'd2:    slot = stored.minute;
      default: slot = stored.hour;
    endcase
    slot = piece[0] ? (slot | {nib, 4'd0}) : {4'd0, nib};
    cnt_o = stored;
    case (piece[2:1])
      2'd0:    cnt_o.frame  = slot;
      2'd1:    cnt_o.second = slot;
      2'd2:    cnt_o.minute = slot;
      default: cnt_o.hour   = slot;
    endcase
    rate_o = rate_i;
    if (piece == mtcqf_pkg::PIECE_HOUR_HI) begin
      cnt_o.hour = {3'd0, cnt_o.hour[4:0]};
      rate_o     = mtcqf_pkg::rate_of_kind(nib[3:1]);
    end
  end

endmodule

// ===== design/mtc_quarter_frame_decoder.sv =====
// Channel   Dir  Payload                         Request taken when
// msg_in    in   status_byte[7:0] data_byte[6:0]  valid && ready
// time_out  out  time_ms[26:0] time_valid         valid && ready
// cfg_wr    in   index[0] wdata[7:0]              valid && ready (always ready)
//
// One message per cycle while the output is not stalled: a message waits in the input register,
// where the counter update and time conversion run, then a result goes to
// the output register, which drives time_out.
// Messages that make no result pass through without waiting on the output.
// Reset clears the counters, sets enable and selects 25 fps.
// A stalled output holds only messages that would make a new result.
module mtc_quarter_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  mtcqf_msg_if.sink          msg_in,
  mtcqf_time_if.source       time_out,
  mtcqf_cfg_if.sink          cfg_wr
);

  logic                   in_valid_q;
  logic [7:0]             in_status_q;
  logic [6:0]             in_data_q;
  logic                   enable_q;
  mtcqf_pkg::rate_e       rate_q, rate_d;
  mtcqf_pkg::cnt_t        cnt_q, cnt_d;
  logic                   out_valid_q;
  logic [26:0]            out_ms_q;
  logic                   out_ok_q;
  mtcqf_pkg::dec_res_t    dec;
  logic                   act;
  logic                   emit;
  logic                   advance;

  mtcqf_decode u_decode (
    .cnt_i       (cnt_q),
    .rate_i      (rate_q),
    .data_byte_i (in_data_q),
    .cnt_o       (cnt_d),
    .rate_o      (rate_d),
    .res_o       (dec)
  );

  // Stage control
  assign act     = in_valid_q && enable_q && (in_status_q == mtcqf_pkg::MTC_STATUS);
  assign emit    = act && dec.emit;
  assign advance = in_valid_q && (!emit || !out_valid_q || time_out.ready);

  assign msg_in.ready = !in_valid_q || advance;
  assign cfg_wr.ready = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (msg_in.ready) begin
      in_valid_q <= msg_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_in.valid && msg_in.ready) begin
      in_status_q <= msg_in.status_byte;
      in_data_q   <= msg_in.data_byte;
    end
  end

  // Timecode state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      rate_q   <= mtcqf_pkg::RATE_25;
      cnt_q    <= '0;
    end else begin
      if (advance && act) begin
        cnt_q  <= cnt_d;
        rate_q <= rate_d;
      end
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          mtcqf_pkg::REG_ENABLE:     enable_q <= cfg_wr.wdata[0];
          mtcqf_pkg::REG_FRAME_RATE: rate_q   <= mtcqf_pkg::rate_of_fps(cfg_wr.wdata);
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (time_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_ms_q <= dec.time_ms;
      out_ok_q <= dec.time_valid;
    end
  end

  assign time_out.valid      = out_valid_q;
  assign time_out.time_ms    = out_ms_q;
  assign time_out.time_valid = out_ok_q;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Quarter-frame piece indexes (data bits 6:4)
  localparam logic [2:0] PC_FRAME_LO = 3'd0;
  localparam logic [2:0] PC_FRAME_HI = 3'd1;
  localparam logic [2:0] PC_SEC_LO   = 3'd2;
  localparam logic [2:0] PC_SEC_HI   = 3'd3;
  localparam logic [2:0] PC_MIN_LO   = 3'd4;
  localparam logic [2:0] PC_MIN_HI   = 3'd5;
  localparam logic [2:0] PC_HOUR_LO  = 3'd6;

  // SMPTE type carried in the hours-high piece
  localparam logic [1:0] SMPTE_24   = 2'd0;
  localparam logic [1:0] SMPTE_25   = 2'd1;
  localparam logic [1:0] SMPTE_30   = 2'd3;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS   = 182;

  typedef struct packed {
    logic [26:0] ms;
    logic        ok;
  } decoded_time_t;

  // Tracks the timecode counters and queues the times the block must emit
  class timecode_checker;
    bit               enable_q;
    mtcqf_pkg::rate_e rate_q;
    mtcqf_pkg::cnt_t  cnt;
    decoded_time_t    pending_times[$];
    int unsigned      errors, n_msgs, n_checked, n_invalid, n_writes;

    function new();
      enable_q = 1'b1;
      rate_q   = mtcqf_pkg::RATE_25;
      cnt      = '0;
    endfunction

    function int unsigned fps_of(mtcqf_pkg::rate_e r);
      case (r)
        mtcqf_pkg::RATE_24: return 24;
        mtcqf_pkg::RATE_30: return 30;
        default: return 25;
      endcase
    endfunction

    function void write_register(logic [mtcqf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
      n_writes++;
      if (idx == mtcqf_pkg::REG_ENABLE) begin
        enable_q = value[0];
      end else if (idx == mtcqf_pkg::REG_FRAME_RATE) begin
        case (value)
          8'd24:   rate_q = mtcqf_pkg::RATE_24;
          8'd30:   rate_q = mtcqf_pkg::RATE_30;
          default: rate_q = mtcqf_pkg::RATE_25;
        endcase
      end
    endfunction

    // Advance on pieces 0 and 4, emit the time, then load the nibble
    function void note_message(logic [7:0] status, logic [6:0] data);
      logic [2:0]    piece;
      logic [3:0]    nib;
      logic [2:0]    kind;
      logic [7:0]    slot;
      int unsigned   fps, f, s, m, h;
      decoded_time_t rec;
      n_msgs++;
      piece = data[6:4];
      nib   = data[3:0];
      if (enable_q && status == mtcqf_pkg::MTC_STATUS) begin
        fps = fps_of(rate_q);
        if (piece[1:0] == 2'b00) begin
          f = cnt.frame + 1;
          if (f >= fps) begin
            s = cnt.second + 1;
            f = f % fps;
            if (s >= 60) begin
              m = cnt.minute + 1;
              s = s % 60;
              if (m >= 60) begin
                m = m % 60;
                cnt.hour = cnt.hour + 8'd1;
              end
              cnt.minute = m[7:0];
            end
            cnt.second = s[7:0];
          end
          cnt.frame = f[7:0];
          rec.ok = (cnt.hour < 8'd24) && (cnt.minute < 8'd60) && (cnt.second < 8'd60);
          rec.ms = '0;
          if (rec.ok) begin
            h = cnt.hour;
            m = cnt.minute;
            s = cnt.second;
            f = cnt.frame;
            rec.ms = 27'(h * 3600000 + m * 60000 + s * 1000 + (f * 1000) / fps);
          end
          pending_times.push_back(rec);
        end
        // low pieces replace the counter, high pieces OR into bits 7:4
        case (piece[2:1])
          2'd0:    slot = cnt.frame;
          2'd1:    slot = cnt.second;
          2'd2:    slot = cnt.minute;
          default: slot = cnt.hour;
        endcase
        slot = piece[0] ? (slot | {nib, 4'h0}) : {4'h0, nib};
        case (piece[2:1])
          2'd0:    cnt.frame  = slot;
          2'd1:    cnt.second = slot;
          2'd2:    cnt.minute = slot;
          default: cnt.hour   = slot;
        endcase
        if (piece == mtcqf_pkg::PIECE_HOUR_HI) begin
          cnt.hour = cnt.hour & 8'h1F;
          kind = nib[3:1];
          if (kind == 3'd0) rate_q = mtcqf_pkg::RATE_24;
          else if (kind == 3'd1) rate_q = mtcqf_pkg::RATE_25;
          else if (kind <= 3'd3) rate_q = mtcqf_pkg::RATE_30;
          else rate_q = mtcqf_pkg::RATE_25;
        end
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_time(logic [26:0] ms, logic ok);
      decoded_time_t want;
      n_checked++;
      if (pending_times.size() == 0) begin
        report($sformatf("time %0d valid %0b with no request pending", ms, ok));
      end else begin
        want = pending_times.pop_front();
        if (!want.ok) n_invalid++;
        if (ok !== want.ok) report($sformatf("time_valid %0b, want %0b", ok, want.ok));
        if (ms !== want.ms) report($sformatf("time_ms %0d, want %0d", ms, want.ms));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mtcqf_msg_if  msg_ch ();
  mtcqf_time_if time_ch ();
  mtcqf_cfg_if  cfg_ch ();

  mtc_quarter_frame_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .msg_in   (msg_ch),
    .time_out (time_ch),
    .cfg_wr   (cfg_ch)
  );

  timecode_checker sb = new();

  bit          no_gaps;
  bit          hold_output;
  int unsigned items_sent;
  int unsigned stalled_cycles;
  int unsigned holds_done;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [6:0] qf(logic [2:0] piece, logic [3:0] nib);
    return {piece, nib};
  endfunction

  // Offer one message; returns at the falling edge after it is taken
  task automatic send_message(logic [7:0] status, logic [6:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    msg_ch.valid       = 1'b1;
    msg_ch.status_byte = status;
    msg_ch.data_byte   = data;
    do @(posedge clk_i); while (!msg_ch.ready);
    if (status == mtcqf_pkg::MTC_STATUS) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [mtcqf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.wdata = value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(logic en, logic [7:0] fps);
    write_cfg(mtcqf_pkg::REG_ENABLE, {7'd0, en});
    write_cfg(mtcqf_pkg::REG_FRAME_RATE, fps);
  endtask

  // Drain: all times back, plus the pipeline depth for silent messages
  task automatic wait_idle();
    msg_ch.valid = 1'b0;
    while (sb.pending_times.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Eight pieces of a plausible timecode, sometimes reversed or cut short
  task automatic send_full_frame(bit broken);
    logic [7:0] fr, se, mi, ho;
    logic [1:0] kind;
    logic [3:0] nibs [8];
    logic [2:0] p, start;
    int unsigned len;
    bit backward;
    fr   = 8'($urandom_range(0, 29));
    se   = 8'($urandom_range(0, 59));
    mi   = 8'($urandom_range(0, 59));
    ho   = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(24, 31)) : 8'($urandom_range(0, 23));
    kind = 2'($urandom_range(0, 3));
    nibs[PC_FRAME_LO]   = fr[3:0];
    nibs[PC_FRAME_HI]   = {3'd0, fr[4]};
    nibs[PC_SEC_LO]     = se[3:0];
    nibs[PC_SEC_HI]     = {2'd0, se[5:4]};
    nibs[PC_MIN_LO]     = mi[3:0];
    nibs[PC_MIN_HI]     = {2'd0, mi[5:4]};
    nibs[PC_HOUR_LO]    = ho[3:0];
    nibs[mtcqf_pkg::PIECE_HOUR_HI] = {1'b0, kind, ho[4]};
    if ($urandom_range(0, 7) == 0) nibs[mtcqf_pkg::PIECE_HOUR_HI][3] = 1'b1;
    if ($urandom_range(0, 9) == 0) nibs[$urandom_range(0, 7)] = 4'($urandom_range(0, 15));
    backward = ($urandom_range(0, 4) == 0);
    start    = broken ? 3'($urandom_range(0, 7)) : 3'd0;
    len      = broken ? $urandom_range(1, 7) : 8;
    for (int i = 0; i < len; i++) begin
      p = start + 3'(i);
      if (backward) p = 3'd7 - p;
      send_message(mtcqf_pkg::MTC_STATUS, qf(p, nibs[p]));
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) send_message(8'($urandom_range(0, 255)), 7'($urandom));
    else send_message(mtcqf_pkg::MTC_STATUS, 7'($urandom));
  endtask

  // Accepted requests, results and register writes go to the checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (msg_ch.valid && msg_ch.ready) sb.note_message(msg_ch.status_byte, msg_ch.data_byte);
      if (time_ch.valid && time_ch.ready) sb.check_time(time_ch.time_ms, time_ch.time_valid);
      if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.index, cfg_ch.wdata);
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((msg_ch.valid && msg_ch.ready) || (time_ch.valid && time_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("timeout: no request taken for %0d cycles", stalled_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Output side: random back-pressure, one long hold on request
  initial begin
    int unsigned gap;
    time_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        time_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_output = 1'b0;
        holds_done++;
      end
      gap = pick_gap();
      time_ch.ready = (gap == 0);
      if (gap > 1) repeat (gap - 1) @(negedge clk_i);
    end
  end

  // Stimulus
  initial begin
    logic [7:0] rate_plan [NUM_PHASES];
    int unsigned target;
    int unsigned r;
    rate_plan = '{8'd25, 8'd24, 8'd30, 8'd0, 8'd255, 8'd30, 8'd24, 8'd29, 8'd25, 8'd25};
    rate_plan[NUM_PHASES-1] = 8'($urandom_range(0, 255));
    msg_ch.valid       = 1'b0;
    msg_ch.status_byte = '0;
    msg_ch.data_byte   = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.wdata       = '0;
    no_gaps            = 1'b0;
    hold_output        = 1'b0;
    rst_ni             = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: ignored statuses, counters pushed past range
    configure(1'b1, 8'd25);
    send_message(8'hF0, 7'h00);
    send_message(8'hFF, 7'h7F);
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_LO, 4'h0));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_HI, 4'hF));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_MIN_LO, 4'h0));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_SEC_LO, 4'hF));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_SEC_HI, 4'hF));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_MIN_HI, 4'hF));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_HOUR_LO, 4'hF));
    send_message(mtcqf_pkg::MTC_STATUS, qf(mtcqf_pkg::PIECE_HOUR_HI, 4'hF));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_LO, 4'h0));
    // 23:59:59 frame 24 at 25 fps, then roll over past midnight
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_MIN_LO, 4'hB));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_MIN_HI, 4'h3));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_HOUR_LO, 4'h7));
    send_message(mtcqf_pkg::MTC_STATUS, qf(mtcqf_pkg::PIECE_HOUR_HI, {1'b0, SMPTE_25, 1'b1}));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_SEC_LO, 4'hB));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_SEC_HI, 4'h3));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_LO, 4'h8));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_HI, 4'h1));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_MIN_LO, 4'h0));
    // rate taken from the SMPTE type, including the unused types
    send_message(mtcqf_pkg::MTC_STATUS, qf(mtcqf_pkg::PIECE_HOUR_HI, {1'b0, SMPTE_24, 1'b0}));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_HOUR_LO, 4'h0));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_LO, 4'h5));
    send_message(mtcqf_pkg::MTC_STATUS, qf(mtcqf_pkg::PIECE_HOUR_HI, {1'b0, SMPTE_30, 1'b0}));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_MIN_LO, 4'h1));
    send_message(mtcqf_pkg::MTC_STATUS, qf(mtcqf_pkg::PIECE_HOUR_HI, 4'hC));
    send_message(mtcqf_pkg::MTC_STATUS, qf(PC_FRAME_LO, 4'h0));
    wait_idle();

    // Random phases, each with its own rate setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 5) begin
        // disabled: everything must be dropped
        configure(1'b0, 8'd30);
        repeat (40) begin
          if ($urandom_range(0, 1) == 0) send_noise();
          else send_message(mtcqf_pkg::MTC_STATUS, 7'($urandom));
        end
        wait_idle();
      end
      configure(1'b1, rate_plan[ph]);
      no_gaps = (ph % 3 == 2) || (ph == 3);
      if (ph == 3) hold_output = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(0, 9);
        if (r < 8) send_full_frame(r == 7);
        else send_noise();
      end
      wait_idle();
    end

    no_gaps = 1'b0;
    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("Covered %0d messages (%0d quarter frames), %0d times checked, %0d out of range.",
             sb.n_msgs, items_sent, sb.n_checked, sb.n_invalid);
    $display("%0d register writes over %0d rate phases, %0d long output holds.",
             sb.n_writes, NUM_PHASES, holds_done);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== mtc_quarter_frame_decoder.f =====
design/mtcqf_pkg.sv
design/mtcqf_if.sv
design/mtcqf_decode.sv
design/mtc_quarter_frame_decoder.sv
verif/testbench.sv
